@@ rtl/cle_pkg.sv @@
package cle_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int CUR_W      = $clog2(LINE_DEPTH);
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int UPC_W      = 4;

  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_CTRL_W = 8'h17;
  localparam logic [CHAR_W-1:0] CH_CTRL_U = 8'h15;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [0:0] {
    OP_RX   = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ECHO_NONE    = 2'd0,
    ECHO_CHAR    = 2'd1,
    ECHO_NEWLINE = 2'd2
  } echo_kind_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_CUR_ZERO,
    COND_CUR_FULL,
    COND_STOP_WORD,
    COND_CUR_GT_ONE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    RAM_NONE,
    RAM_WRITE,
    RAM_READ_IDX,
    RAM_READ_PREV
  } ram_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_INC,
    CUR_DEC,
    CUR_CLEAR
  } cur_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_LOAD_CUR
  } cnt_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_NEWLINE,
    RES_ECHO,
    RES_RDATA
  } res_op_t;

  typedef struct packed {
    cond_t   cond;
    upc_t    target;
    logic    hold;
    logic    take_in;
    logic    emit;
    ram_op_t ram_op;
    cur_op_t cur_op;
    cnt_op_t cnt_op;
    res_op_t res_op;
    logic    seen_upd;
  } ctrl_t;

  typedef struct packed {
    logic cur_zero;
    logic cur_full;
    logic cur_gt_one;
    logic stop_word;
    logic out_free;
  } stat_t;

  // microprogram entry points and steps
  localparam upc_t A_FETCH    = upc_t'(0);
  localparam upc_t A_NEWLINE  = upc_t'(1);
  localparam upc_t A_BS       = upc_t'(2);
  localparam upc_t A_BS_DO    = upc_t'(3);
  localparam upc_t A_KILL     = upc_t'(4);
  localparam upc_t A_PRINT    = upc_t'(5);
  localparam upc_t A_PRINT_DO = upc_t'(6);
  localparam upc_t A_READ     = upc_t'(7);
  localparam upc_t A_READ_DO  = upc_t'(8);
  localparam upc_t A_WORD     = upc_t'(9);
  localparam upc_t A_WORD_RD  = upc_t'(10);
  localparam upc_t A_WORD_CHK = upc_t'(11);
  localparam upc_t A_WORD_DO  = upc_t'(12);
  localparam upc_t A_EMIT     = upc_t'(13);

  function automatic ctrl_t ucode(upc_t addr);
    ctrl_t w;
    w = '0;
    unique case (addr)
      A_FETCH: begin
        w.cond    = COND_DISPATCH;
        w.hold    = 1'b1;
        w.take_in = 1'b1;
      end
      A_NEWLINE: begin
        w.res_op = RES_NEWLINE;
        w.cond   = COND_ALWAYS;
        w.target = A_EMIT;
      end
      A_BS: begin
        w.cond   = COND_CUR_ZERO;
        w.target = A_EMIT;
      end
      A_BS_DO: begin
        w.cur_op = CUR_DEC;
        w.cnt_op = CNT_INC;
        w.cond   = COND_ALWAYS;
        w.target = A_EMIT;
      end
      A_KILL: begin
        w.cnt_op = CNT_LOAD_CUR;
        w.cur_op = CUR_CLEAR;
        w.cond   = COND_ALWAYS;
        w.target = A_EMIT;
      end
      A_PRINT: begin
        w.cond   = COND_CUR_FULL;
        w.target = A_EMIT;
      end
      A_PRINT_DO: begin
        w.ram_op = RAM_WRITE;
        w.cur_op = CUR_INC;
        w.res_op = RES_ECHO;
        w.cond   = COND_ALWAYS;
        w.target = A_EMIT;
      end
      A_READ: begin
        w.ram_op = RAM_READ_IDX;
      end
      A_READ_DO: begin
        w.res_op = RES_RDATA;
        w.cond   = COND_ALWAYS;
        w.target = A_EMIT;
      end
      A_WORD: begin
        w.cond   = COND_CUR_ZERO;
        w.target = A_EMIT;
      end
      A_WORD_RD: begin
        w.ram_op = RAM_READ_PREV;
      end
      A_WORD_CHK: begin
        w.cond   = COND_STOP_WORD;
        w.target = A_EMIT;
      end
      A_WORD_DO: begin
        w.cur_op   = CUR_DEC;
        w.cnt_op   = CNT_INC;
        w.seen_upd = 1'b1;
        w.cond     = COND_CUR_GT_ONE;
        w.target   = A_WORD_RD;
      end
      A_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = A_FETCH;
        w.hold   = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = A_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(logic op, logic [CHAR_W-1:0] ch);
    upc_t a;
    priority if (op == OP_READ)                  a = A_READ;
    else if (ch == CH_CR || ch == CH_LF)         a = A_NEWLINE;
    else if (ch == CH_BS || ch == CH_DEL)        a = A_BS;
    else if (ch == CH_CTRL_W)                    a = A_WORD;
    else if (ch == CH_CTRL_U)                    a = A_KILL;
    else if (ch >= CH_SPACE && ch < CH_DEL)      a = A_PRINT;
    else                                         a = A_EMIT;
    return a;
  endfunction

endpackage

@@ rtl/cle_ram.sv @@
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/cle_seq.sv @@
module cle_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          opcode,
  input  logic [cle_pkg::CHAR_W-1:0]    rx_char,
  input  cle_pkg::stat_t                stat,
  output cle_pkg::ctrl_t                ctrl
);
  import cle_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic taken;

  assign ctrl = ucode(upc);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    taken = 1'b0;
    unique case (ctrl.cond)
      COND_NEVER:      taken = 1'b0;
      COND_ALWAYS:     taken = 1'b1;
      COND_DISPATCH:   taken = in_valid;
      COND_CUR_ZERO:   taken = stat.cur_zero;
      COND_CUR_FULL:   taken = stat.cur_full;
      COND_STOP_WORD:  taken = stat.stop_word;
      COND_CUR_GT_ONE: taken = stat.cur_gt_one;
      COND_OUT_FREE:   taken = stat.out_free;
      default:         taken = 1'b0;
    endcase

    if (taken) begin
      upc_next = (ctrl.cond == COND_DISPATCH) ? dispatch(opcode, rx_char) : ctrl.target;
    end else if (ctrl.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  // an accepted beat always leaves the fetch step
  a_leave_fetch: assert property (@(posedge clk) disable iff (rst)
    (upc == A_FETCH && in_valid) |=> upc != A_FETCH)
    else $error("sequencer stayed in fetch after accepting a beat");

  // the word walk only loops back while characters remain
  a_word_loop: assert property (@(posedge clk) disable iff (rst)
    (upc == A_WORD_RD) |-> !stat.cur_zero)
    else $error("word erase read below the start of the line");

endmodule

@@ rtl/cle_dp.sv @@
module cle_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cle_pkg::ctrl_t                ctrl,
  output cle_pkg::stat_t                stat,
  input  logic                          in_valid,
  input  logic [cle_pkg::CHAR_W-1:0]    rx_char,
  input  logic [cle_pkg::CHAR_W-1:0]    read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    echo_kind,
  output logic [cle_pkg::CHAR_W-1:0]    echo_char,
  output logic [cle_pkg::COUNT_W-1:0]   erase_count,
  output logic                          line_done,
  output logic [cle_pkg::COUNT_W-1:0]   line_length,
  output logic [cle_pkg::CHAR_W-1:0]    read_data
);
  import cle_pkg::*;

  logic [CHAR_W-1:0]  ch;
  logic [CHAR_W-1:0]  idx;
  logic [CUR_W-1:0]   cursor;
  logic [CUR_W-1:0]   cursor_next;
  logic [COUNT_W-1:0] cnt;
  logic               seen;
  echo_kind_t         kind;
  logic [CHAR_W-1:0]  echo;
  logic               done;
  logic [CHAR_W-1:0]  rdata;

  logic               ram_en;
  logic               ram_we;
  logic [CUR_W-1:0]   ram_addr;
  logic [CHAR_W-1:0]  ram_q;
  logic               idx_ok;
  logic               take;
  logic               load_out;

  assign take     = ctrl.take_in && in_valid;
  assign load_out = ctrl.emit && stat.out_free;
  assign idx_ok   = ({1'b0, idx} < 9'(LINE_DEPTH));

  assign ram_en = (ctrl.ram_op != RAM_NONE);
  assign ram_we = (ctrl.ram_op == RAM_WRITE);

  always_comb begin
    unique case (ctrl.ram_op)
      RAM_NONE:      ram_addr = cursor;
      RAM_WRITE:     ram_addr = cursor;
      RAM_READ_IDX:  ram_addr = idx[CUR_W-1:0];
      RAM_READ_PREV: ram_addr = cursor - CUR_W'(1);
      default:       ram_addr = cursor;
    endcase
  end

  cle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ch),
    .rdata (ram_q)
  );

  always_comb begin
    stat.cur_zero   = (cursor == '0);
    stat.cur_full   = (cursor == CUR_W'(LINE_DEPTH - 1));
    stat.cur_gt_one = (cursor > CUR_W'(1));
    // a space after the word has been seen stops the walk
    stat.stop_word  = seen && (ram_q == CH_SPACE);
    stat.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    unique case (ctrl.cur_op)
      CUR_HOLD:  cursor_next = cursor;
      CUR_INC:   cursor_next = cursor + CUR_W'(1);
      CUR_DEC:   cursor_next = cursor - CUR_W'(1);
      CUR_CLEAR: cursor_next = '0;
      default:   cursor_next = cursor;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      cursor <= cursor_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch    <= rx_char;
      idx   <= read_index;
      cnt   <= '0;
      seen  <= 1'b0;
      kind  <= ECHO_NONE;
      echo  <= '0;
      done  <= 1'b0;
      rdata <= '0;
    end else begin
      unique case (ctrl.cnt_op)
        CNT_HOLD:     cnt <= cnt;
        CNT_INC:      cnt <= cnt + COUNT_W'(1);
        CNT_LOAD_CUR: cnt <= COUNT_W'(cursor);
        default:      cnt <= cnt;
      endcase
      if (ctrl.seen_upd) begin
        seen <= seen | (ram_q != CH_SPACE);
      end
      unique case (ctrl.res_op)
        RES_NONE: ;
        RES_NEWLINE: begin
          kind <= ECHO_NEWLINE;
          done <= 1'b1;
        end
        RES_ECHO: begin
          kind <= ECHO_CHAR;
          echo <= ch;
        end
        RES_RDATA: rdata <= idx_ok ? ram_q : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      echo_kind   <= kind;
      echo_char   <= echo;
      erase_count <= cnt;
      line_done   <= done;
      line_length <= COUNT_W'(cursor);
      read_data   <= rdata;
    end
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ram_op == RAM_WRITE) |-> !stat.cur_full)
    else $error("line store written with the line full");

  a_no_dec_empty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cur_op == CUR_DEC) |-> !stat.cur_zero)
    else $error("cursor decremented below zero");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result beat not presented after emit");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_W'(LINE_DEPTH - 1))
    else $error("cursor beyond line depth");

endmodule

@@ rtl/console_line_editor_core.sv @@
// console line editor
// in channel: in_valid/in_stall with opcode, rx_char and read_index. opcode 0 feeds
// one received console byte to the editor, opcode 1 reads one stored line byte.
// out channel: out_valid/out_stall with one result beat per input beat: echo_kind,
// echo_char, erase_count, line_done, line_length and read_data.
// a small microprogram steps a datapath holding the cursor and a 256 byte line ram.
// each item runs from the fetch step through the steps of its kind to the emit step;
// ignored bytes go straight to emit, and a backspace on an empty line or a printable
// byte on a full line skips its action step. a word erase walks back one character
// per loop and does one ram read per character walked, stopping at the start of the
// line or at a space before the word.
// the result beat is shown in the cycle after the emit step loads it; the next beat is taken
// right after that while the result waits in its register.
// reset clears the cursor and the output valid and holds in_stall high; the line
// ram is not cleared and a read of a never written position returns whatever it holds.
// while out_stall is high the result holds; the sequencer waits at its emit step
// with the next result and keeps in_stall high until the register frees.
module console_line_editor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [cle_pkg::CHAR_W-1:0]    rx_char,
  input  logic [cle_pkg::CHAR_W-1:0]    read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    echo_kind,
  output logic [cle_pkg::CHAR_W-1:0]    echo_char,
  output logic [cle_pkg::COUNT_W-1:0]   erase_count,
  output logic                          line_done,
  output logic [cle_pkg::COUNT_W-1:0]   line_length,
  output logic [cle_pkg::CHAR_W-1:0]    read_data
);
  import cle_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign in_stall = rst || !ctrl.take_in;

  cle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .rx_char  (rx_char),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  cle_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_valid    (in_valid),
    .rx_char     (rx_char),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .echo_kind   (echo_kind),
    .echo_char   (echo_char),
    .erase_count (erase_count),
    .line_done   (line_done),
    .line_length (line_length),
    .read_data   (read_data)
  );

endmodule
